/* src/bpr_pkg.sv */
// Package for the box placement relation block: widths, register map and relation codes.
// No dependencies; imported by box_placement_relation.
package bpr_pkg;

    localparam int COORD_BITS = 16;                 // box bound width, two's complement

    localparam int C2_W    = COORD_BITS + 1;        // doubled centre / doubled bound
    localparam int SIDE_W  = COORD_BITS;            // |max - min|
    localparam int DELTA_W = C2_W;                  // |centre2 - centre2|
    localparam int SQD_W   = 2 * DELTA_W;           // delta squared
    localparam int DIST_W  = SQD_W + 1;             // dx^2 + dy^2
    localparam int SQS_W   = 2 * SIDE_W;            // side squared

    localparam int GAP_W = 15;
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(50);
    localparam int CMP_W = (C2_W > GAP_W + 1) ? C2_W : GAP_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_GAP_IDX = 1'b0;            // paddr[2] of on_gap_limit

    typedef logic [1:0] t_rel;
    localparam t_rel REL_NONE = 2'd0;
    localparam t_rel REL_IN   = 2'd1;
    localparam t_rel REL_ON   = 2'd2;
    localparam t_rel REL_NEXT = 2'd3;

    typedef logic signed [C2_W-1:0] t_c2;

endpackage

/* src/box_placement_relation.sv */
// Box placement relation: five-stage pipeline classifying a source box against a target box.
// Depends on bpr_pkg (widths, register map, relation codes).
//
// Channel | direction | handshake                  | payload
// --------+-----------+----------------------------+------------------------------------------
// in      | input     | i_in_valid / o_in_ready    | i_src_{x,y,z}_{min,max}, i_tgt_{x,y,z}_{min,max}
// out     | output    | o_out_valid / i_out_ready  | o_relation
// cfg     | input     | psel, penable, pwrite, ... | on_gap_limit at byte address 0
//
// One item per cycle sustained while the output is not stalled; each item is registered in r1 to r5 before o_out_valid.
// Stages: centres/sides, in/on tests and deltas, squaring, distance sum, compare and priority.
// The squaring stage (17x17 and 16x16 multipliers) sets the critical path.
// Synchronous active-low reset clears all valid bits and loads the gap limit with 50.
// The pipeline advances as a whole whenever the output register is empty or being taken,
// so a downstream stall freezes every stage in place and nothing is dropped or repeated.
module box_placement_relation
    import bpr_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_src_x_min,
    input  logic signed [COORD_BITS-1:0] i_src_x_max,
    input  logic signed [COORD_BITS-1:0] i_src_y_min,
    input  logic signed [COORD_BITS-1:0] i_src_y_max,
    input  logic signed [COORD_BITS-1:0] i_src_z_min,
    input  logic signed [COORD_BITS-1:0] i_src_z_max,
    input  logic signed [COORD_BITS-1:0] i_tgt_x_min,
    input  logic signed [COORD_BITS-1:0] i_tgt_x_max,
    input  logic signed [COORD_BITS-1:0] i_tgt_y_min,
    input  logic signed [COORD_BITS-1:0] i_tgt_y_max,
    input  logic signed [COORD_BITS-1:0] i_tgt_z_min,
    input  logic signed [COORD_BITS-1:0] i_tgt_z_max,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_relation,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [GAP_W-1:0] r_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_GAP_IDX)) begin
            r_gap <= pwdata[GAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAP_IDX) ? PDATA_W'(r_gap) : '0;

    // Whole pipeline moves together; stall only when the output holds an untaken item
    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ------------------------------------------------------------------
    // Stage 1: doubled centres, doubled target bounds, side lengths, z tests
    // ------------------------------------------------------------------
    t_c2              n1_sc [3];
    t_c2              n1_tc [2];
    t_c2              n1_t2 [6];
    logic [SIDE_W-1:0] n1_ssx, n1_ssy, n1_tsx, n1_tsy;
    t_c2              n1_zgap;
    logic             n1_zov;
    t_c2              n1_dsx, n1_dsy, n1_dtx, n1_dty;
    logic [C2_W-1:0]  n1_msx, n1_msy, n1_mtx, n1_mty;

    always_comb begin
        n1_sc[0] = C2_W'(i_src_x_min) + C2_W'(i_src_x_max);
        n1_sc[1] = C2_W'(i_src_y_min) + C2_W'(i_src_y_max);
        n1_sc[2] = C2_W'(i_src_z_min) + C2_W'(i_src_z_max);
        n1_tc[0] = C2_W'(i_tgt_x_min) + C2_W'(i_tgt_x_max);
        n1_tc[1] = C2_W'(i_tgt_y_min) + C2_W'(i_tgt_y_max);

        n1_t2[0] = {i_tgt_x_min, 1'b0};
        n1_t2[1] = {i_tgt_x_max, 1'b0};
        n1_t2[2] = {i_tgt_y_min, 1'b0};
        n1_t2[3] = {i_tgt_y_max, 1'b0};
        n1_t2[4] = {i_tgt_z_min, 1'b0};
        n1_t2[5] = {i_tgt_z_max, 1'b0};

        n1_dsx = C2_W'(i_src_x_max) - C2_W'(i_src_x_min);
        n1_dsy = C2_W'(i_src_y_max) - C2_W'(i_src_y_min);
        n1_dtx = C2_W'(i_tgt_x_max) - C2_W'(i_tgt_x_min);
        n1_dty = C2_W'(i_tgt_y_max) - C2_W'(i_tgt_y_min);
        n1_msx = n1_dsx[C2_W-1] ? (~n1_dsx + 1'b1) : n1_dsx;
        n1_msy = n1_dsy[C2_W-1] ? (~n1_dsy + 1'b1) : n1_dsy;
        n1_mtx = n1_dtx[C2_W-1] ? (~n1_dtx + 1'b1) : n1_dtx;
        n1_mty = n1_dty[C2_W-1] ? (~n1_dty + 1'b1) : n1_dty;
        n1_ssx = n1_msx[SIDE_W-1:0];
        n1_ssy = n1_msy[SIDE_W-1:0];
        n1_tsx = n1_mtx[SIDE_W-1:0];
        n1_tsy = n1_mty[SIDE_W-1:0];

        // gap between source bottom and target top
        n1_zgap = C2_W'(i_src_z_min) - C2_W'(i_tgt_z_max);
        // z spans overlap; the test is symmetric so it serves both directions
        n1_zov  = !((i_src_z_max <= i_tgt_z_min) || (i_src_z_min >= i_tgt_z_max));
    end

    logic              r1_v;
    t_c2               r1_sc [3];
    t_c2               r1_tc [2];
    t_c2               r1_t2 [6];
    logic [SIDE_W-1:0] r1_ssx, r1_ssy, r1_tsx, r1_tsy;
    t_c2               r1_zgap;
    logic              r1_zov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sc   <= n1_sc;
            r1_tc   <= n1_tc;
            r1_t2   <= n1_t2;
            r1_ssx  <= n1_ssx;
            r1_ssy  <= n1_ssy;
            r1_tsx  <= n1_tsx;
            r1_tsy  <= n1_tsy;
            r1_zgap <= n1_zgap;
            r1_zov  <= n1_zov;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: in / on tests, centre deltas, larger side of each box
    // ------------------------------------------------------------------
    logic                     n2_xy_in, n2_in, n2_on;
    logic signed [CMP_W-1:0]  n2_zg, n2_gl;
    logic signed [C2_W:0]     n2_ddx, n2_ddy;
    logic [C2_W:0]            n2_mdx, n2_mdy;
    logic [DELTA_W-1:0]       n2_dx, n2_dy;
    logic [SIDE_W-1:0]        n2_ss, n2_ts;

    always_comb begin
        n2_xy_in = (r1_t2[0] <= r1_sc[0]) && (r1_sc[0] <= r1_t2[1]) &&
                   (r1_t2[2] <= r1_sc[1]) && (r1_sc[1] <= r1_t2[3]);
        n2_in    = n2_xy_in && (r1_t2[4] <= r1_sc[2]) && (r1_sc[2] <= r1_t2[5]);

        n2_zg = CMP_W'(r1_zgap);
        n2_gl = CMP_W'({1'b0, r_gap});
        n2_on = n2_xy_in && (r1_sc[2] >= r1_t2[5]) &&
                (n2_zg > 0) && (n2_zg < n2_gl);

        n2_ddx = (C2_W+1)'(r1_sc[0]) - (C2_W+1)'(r1_tc[0]);
        n2_ddy = (C2_W+1)'(r1_sc[1]) - (C2_W+1)'(r1_tc[1]);
        n2_mdx = n2_ddx[C2_W] ? (~n2_ddx + 1'b1) : n2_ddx;
        n2_mdy = n2_ddy[C2_W] ? (~n2_ddy + 1'b1) : n2_ddy;
        n2_dx  = n2_mdx[DELTA_W-1:0];
        n2_dy  = n2_mdy[DELTA_W-1:0];

        n2_ss = (r1_ssx > r1_ssy) ? r1_ssx : r1_ssy;
        n2_ts = (r1_tsx > r1_tsy) ? r1_tsx : r1_tsy;
    end

    logic               r2_v, r2_in, r2_on, r2_zov;
    logic [DELTA_W-1:0] r2_dx, r2_dy;
    logic [SIDE_W-1:0]  r2_ss, r2_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_in  <= n2_in;
            r2_on  <= n2_on;
            r2_zov <= r1_zov;
            r2_dx  <= n2_dx;
            r2_dy  <= n2_dy;
            r2_ss  <= n2_ss;
            r2_ts  <= n2_ts;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares (four narrow multipliers)
    // ------------------------------------------------------------------
    logic               r3_v, r3_in, r3_on, r3_zov;
    logic [SQD_W-1:0]   r3_dx2, r3_dy2;
    logic [SQS_W-1:0]   r3_ss2, r3_ts2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_in  <= r2_in;
            r3_on  <= r2_on;
            r3_zov <= r2_zov;
            r3_dx2 <= r2_dx * r2_dx;
            r3_dy2 <= r2_dy * r2_dy;
            r3_ss2 <= r2_ss * r2_ss;
            r3_ts2 <= r2_ts * r2_ts;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squared centre distance, times four (centres are doubled)
    // ------------------------------------------------------------------
    logic               r4_v, r4_in, r4_on, r4_zov;
    logic [DIST_W-1:0]  r4_dist;
    logic [SQS_W-1:0]   r4_ss2, r4_ts2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_in   <= r3_in;
            r4_on   <= r3_on;
            r4_zov  <= r3_zov;
            r4_dist <= DIST_W'(r3_dx2) + DIST_W'(r3_dy2);
            r4_ss2  <= r3_ss2;
            r4_ts2  <= r3_ts2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: next-to window compares and priority encode into output register
    // side/2 < d < side  <=>  side^2 < 4d^2 < 4 side^2
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] n5_s_lo, n5_s_hi, n5_t_lo, n5_t_hi;
    logic              n5_near;
    t_rel              n5_rel;

    always_comb begin
        n5_s_lo = DIST_W'(r4_ss2);
        n5_s_hi = DIST_W'({r4_ss2, 2'b00});
        n5_t_lo = DIST_W'(r4_ts2);
        n5_t_hi = DIST_W'({r4_ts2, 2'b00});
        n5_near = r4_zov &&
                  (((r4_dist > n5_s_lo) && (r4_dist < n5_s_hi)) ||
                   ((r4_dist > n5_t_lo) && (r4_dist < n5_t_hi)));
        if (r4_in) begin
            n5_rel = REL_IN;
        end else if (r4_on) begin
            n5_rel = REL_ON;
        end else if (n5_near) begin
            n5_rel = REL_NEXT;
        end else begin
            n5_rel = REL_NONE;
        end
    end

    logic r5_v;
    t_rel r5_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_rel <= n5_rel;
        end
    end

    assign o_out_valid = r5_v;
    assign o_relation  = r5_rel;

endmodule
